// ===== rtl/core/arithmetic_decoder_static_core_defines.svh =====
// Assertion macros for the static arithmetic decoder core.
// Included by the modules that carry assertions; depends on nothing.
`ifndef ARITHMETIC_DECODER_STATIC_CORE_DEFINES_SVH
`define ARITHMETIC_DECODER_STATIC_CORE_DEFINES_SVH

// same-cycle implication
`define ADSC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ADSC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/adsc_pkg.sv =====
// Shared types and constants of the static arithmetic decoder core.
// No dependencies; used by the channel interfaces and the core.
package adsc_pkg;

  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned COUNT_W     = 14;
  localparam int unsigned SYM_W       = 4;
  localparam int unsigned SEQ_W       = 16;
  localparam int unsigned RES_W       = 5;
  localparam int unsigned CUM_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned RES_MIN     = 3;
  localparam int unsigned RES_RST     = 16;
  localparam int unsigned SEQ_RST     = 1;
  localparam int unsigned MAX_RESULTS = 16;
  localparam logic [CUM_W-1:0] CUM_MAX = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_COUNT = 2'd1,
    FUNC_BIT   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEQ_LEN    = 2'd0,
    REG_RESOLUTION = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    func_t              func;
    logic [COUNT_W-1:0] count;
    logic               code_bit;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done_res;
    logic             overrun;
  } out_word_t;

  typedef struct packed {
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TMUL,
    ST_TDIV,
    ST_SRD,
    ST_SCMP,
    ST_HMUL,
    ST_HDIV,
    ST_LMUL,
    ST_LDIV,
    ST_EMIT,
    ST_ENDRUN,
    ST_FINAL
  } state_t;

endpackage

// ===== rtl/core/adsc_if.sv =====
// Valid/ready channel interfaces of the static arithmetic decoder core.
// Depends on adsc_pkg for the word types.
interface adsc_in_if;
  logic                valid;
  logic                ready;
  adsc_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface adsc_out_if;
  logic                valid;
  logic                ready;
  adsc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface adsc_cfg_if;
  logic                valid;
  logic                ready;
  adsc_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/arithmetic_decoder_static_core.sv =====
// Static-model arithmetic decoder with E1/E2/E3 rescaling: table memory, shared serial divider.
// Depends on adsc_pkg, adsc_if.sv and arithmetic_decoder_static_core_defines.svh.
//
// channel  dir  word                         handshake
// item     in   func, count, code_bit        valid & ready
// result   out  symbol, last, done_res, ovr  valid & ready
// cfg      in   index, value                 valid & ready (ready tied high)
//
// Clear, count and fill words are handled in the idle state; the fill word that completes the
// tag starts decoding. A decoded symbol costs three passes of the shared restoring divider plus
// a read and a compare step per table entry searched in the table memory.
// Reset (rst, synchronous) restores the control registers and an empty table; no clearing pass.
// One item is worked on at a time; a result word waits in the output register while the
// next item is taken, and a stalled result side holds the decoder at its next emit or run end.
`include "arithmetic_decoder_static_core_defines.svh"

module arithmetic_decoder_static_core #(
  parameter int unsigned NSYM    = 16,
  parameter int unsigned PREC    = 16,
  parameter int unsigned MAX_RUN = 16
) (
  input  logic clk,
  input  logic rst,
  adsc_in_if.sink    item,
  adsc_out_if.source result,
  adsc_cfg_if.sink   cfg
);

  localparam int unsigned CUM_W   = adsc_pkg::CUM_W;
  localparam int unsigned SYM_W   = adsc_pkg::SYM_W;
  localparam int unsigned AW      = $clog2(NSYM + 1);
  localparam int unsigned SW      = (NSYM > 2) ? $clog2(NSYM) : 1;
  localparam int unsigned RW      = $clog2(PREC + 1);
  localparam int unsigned VW      = PREC + 1;
  localparam int unsigned NW      = VW + CUM_W;
  localparam int unsigned DW      = (VW > CUM_W) ? VW : CUM_W;
  localparam int unsigned CW      = $clog2(NW + 1);
  localparam int unsigned NNW     = $clog2(adsc_pkg::MAX_RESULTS + 1);
  localparam int unsigned RUN_CAP = (MAX_RUN < adsc_pkg::MAX_RESULTS) ?
                                    MAX_RUN : adsc_pkg::MAX_RESULTS;
  localparam int unsigned RST_R   = (adsc_pkg::RES_RST > PREC) ? PREC : adsc_pkg::RES_RST;
  localparam logic [PREC:0] RST_MASK_W = ({{PREC{1'b0}}, 1'b1} << RST_R) - 1'b1;

  // registers
  adsc_pkg::state_t    st, st_next;
  logic [adsc_pkg::SEQ_W-1:0] seq_len;
  logic [adsc_pkg::RES_W-1:0] resolution;
  logic [AW-1:0]       loaded;
  logic [CUM_W-1:0]    total;
  logic [PREC-1:0]     lo, hi, tag, nh;
  logic [RW-1:0]       fill;
  logic [adsc_pkg::SEQ_W-1:0] decoded;
  logic                finished;
  logic [NNW-1:0]      n_cnt;
  logic                ovr, phase_b, bit_q;
  logic [SW-1:0]       s;
  logic [CUM_W-1:0]    prev_c, c_hi, tn, rd_q;
  logic [NW-1:0]       num;
  logic [DW:0]         rem;
  logic [DW-1:0]       den;
  logic [CW-1:0]       dcnt;
  adsc_pkg::out_word_t pend, out_q;
  logic                pend_v, out_v;
  logic [CUM_W-1:0]    mem [1:NSYM];

  // combinational
  logic [RW-1:0]       r_eff, rm1, rm2, fill_inc;
  logic [PREC:0]       mask_w;
  logic [PREC-1:0]     m, half, lo_t, hi_t, lo_s, hi_s, tag_sh, lo_sh, hi_sh;
  logic                pending, e12;
  logic [VW-1:0]       width_v, offs_v;
  logic [AW-1:0]       top, s1;
  logic [CUM_W-1:0]    cur;
  logic [DW:0]         rem_sh, rem_nx;
  logic [NW-1:0]       num_nx;
  logic                ge, div_last, scmp_adv, acc, out_take, out_free, emit_go, resc_go;
  logic                out_load;
  logic                fill_path, fill_done;
  logic [adsc_pkg::SEQ_W-1:0] dec_nx;
  logic [CUM_W:0]      cnt_sum;
  logic [CUM_W-1:0]    cnt_sat;
  logic [SW+SYM_W-1:0] sym_ext;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;

  // effective resolution, mask and top-bit tests
  always_comb begin
    if (int'(resolution) < int'(adsc_pkg::RES_MIN)) r_eff = RW'(adsc_pkg::RES_MIN);
    else if (int'(resolution) > int'(PREC))          r_eff = RW'(PREC);
    else                                              r_eff = RW'(resolution);
    rm1     = r_eff - RW'(1);
    rm2     = r_eff - RW'(2);
    mask_w  = ({{PREC{1'b0}}, 1'b1} << r_eff) - 1'b1;
    m       = mask_w[PREC-1:0];
    half    = {{(PREC-1){1'b0}}, 1'b1} << rm1;
    lo_t    = lo >> rm1;
    hi_t    = hi >> rm1;
    lo_s    = lo >> rm2;
    hi_s    = hi >> rm2;
    e12     = (lo_t[0] == hi_t[0]);
    pending = e12 || (lo_s[0] && !hi_s[0]);
    width_v = {1'b0, (hi - lo) & m} + VW'(1);
    offs_v  = {1'b0, (tag - lo) & m} + VW'(1);
    top     = (loaded != '0) ? loaded - AW'(1) : '0;
    s1      = AW'(s) + AW'(1);
    cur     = (s1 <= loaded) ? rd_q : total;
    fill_inc = fill + RW'(1);
    dec_nx  = decoded + 1'b1;
    sym_ext = {{SYM_W{1'b0}}, s};
    cnt_sum = {1'b0, total} + (CUM_W + 1)'(item.data.count);
    cnt_sat = cnt_sum[CUM_W] ? adsc_pkg::CUM_MAX : cnt_sum[CUM_W-1:0];
  end

  // one E1/E2/E3 shift step
  always_comb begin
    tag_sh = {tag[PREC-2:0], bit_q} & m;
    lo_sh  = {lo[PREC-2:0], 1'b0} & m;
    hi_sh  = {hi[PREC-2:0], 1'b1} & m;
    if (!e12) begin
      tag_sh = tag_sh ^ half;
      lo_sh  = lo_sh ^ half;
      hi_sh  = hi_sh ^ half;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem[DW-1:0], num[NW-1]};
    ge       = (rem_sh >= {1'b0, den});
    rem_nx   = ge ? rem_sh - {1'b0, den} : rem_sh;
    num_nx   = {num[NW-2:0], ge};
    div_last = (dcnt == CW'(NW - 1));
  end

  // handshake and sequencing conditions
  always_comb begin
    acc       = item.valid && item.ready;
    out_take  = result.valid && result.ready;
    out_free  = !out_v || out_take;
    emit_go   = !pend_v || out_free;
    out_load  = ((st == adsc_pkg::ST_EMIT) && emit_go && pend_v) ||
                ((st == adsc_pkg::ST_FINAL) && pend_v && out_free);
    scmp_adv  = (AW'(s) < top) && (cur <= tn);
    resc_go   = !phase_b && !finished && (n_cnt < NNW'(RUN_CAP)) && pending;
    fill_path = (fill < r_eff);
    fill_done = (fill_inc >= r_eff);
    mem_we    = acc && (item.data.func == adsc_pkg::FUNC_COUNT) && (int'(loaded) < int'(NSYM));
    mem_wa    = loaded + AW'(1);
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      adsc_pkg::ST_IDLE: begin
        if (acc && item.data.func == adsc_pkg::FUNC_BIT && !finished &&
            (!fill_path || fill_done)) st_next = adsc_pkg::ST_CHECK;
      end
      adsc_pkg::ST_CHECK: begin
        priority if (finished)                 st_next = adsc_pkg::ST_ENDRUN;
        else if (decoded >= seq_len)           st_next = adsc_pkg::ST_ENDRUN;
        else if (pending)                      st_next = adsc_pkg::ST_ENDRUN;
        else if (n_cnt >= NNW'(RUN_CAP))       st_next = adsc_pkg::ST_ENDRUN;
        else if (total == '0)                  st_next = adsc_pkg::ST_EMIT;
        else                                   st_next = adsc_pkg::ST_TMUL;
      end
      adsc_pkg::ST_TMUL:   st_next = adsc_pkg::ST_TDIV;
      adsc_pkg::ST_TDIV:   if (div_last) st_next = adsc_pkg::ST_SRD;
      adsc_pkg::ST_SRD:    st_next = adsc_pkg::ST_SCMP;
      adsc_pkg::ST_SCMP:   st_next = scmp_adv ? adsc_pkg::ST_SRD : adsc_pkg::ST_HMUL;
      adsc_pkg::ST_HMUL:   st_next = adsc_pkg::ST_HDIV;
      adsc_pkg::ST_HDIV:   if (div_last) st_next = adsc_pkg::ST_LMUL;
      adsc_pkg::ST_LMUL:   st_next = adsc_pkg::ST_LDIV;
      adsc_pkg::ST_LDIV:   if (div_last) st_next = adsc_pkg::ST_EMIT;
      adsc_pkg::ST_EMIT:   if (emit_go) st_next = adsc_pkg::ST_CHECK;
      adsc_pkg::ST_ENDRUN: st_next = resc_go ? adsc_pkg::ST_CHECK : adsc_pkg::ST_FINAL;
      adsc_pkg::ST_FINAL:  if (!pend_v || out_free) st_next = adsc_pkg::ST_IDLE;
      default:             st_next = adsc_pkg::ST_IDLE;
    endcase
  end

  // port outputs
  always_comb begin
    item.ready   = (st == adsc_pkg::ST_IDLE);
    result.valid = out_v;
    result.data  = out_q;
    cfg.ready    = 1'b1;
  end

  // table memory: written by count words, read one entry per search step
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= cnt_sat;
    rd_q <= mem[s1];
  end

  // state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= adsc_pkg::ST_IDLE;
      seq_len    <= adsc_pkg::SEQ_W'(adsc_pkg::SEQ_RST);
      resolution <= adsc_pkg::RES_W'(adsc_pkg::RES_RST);
      loaded     <= '0;
      total      <= '0;
      lo         <= '0;
      hi         <= RST_MASK_W[PREC-1:0];
      tag        <= '0;
      fill       <= '0;
      decoded    <= '0;
      finished   <= 1'b0;
      n_cnt      <= '0;
      ovr        <= 1'b0;
      phase_b    <= 1'b0;
      pend_v     <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      st <= st_next;

      // output register valid
      if (out_load)      out_v <= 1'b1;
      else if (out_take) out_v <= 1'b0;

      // configuration writes
      if (cfg.valid) begin
        unique case (cfg.data.index)
          adsc_pkg::REG_SEQ_LEN:    seq_len    <= cfg.data.value;
          adsc_pkg::REG_RESOLUTION: resolution <= cfg.data.value[adsc_pkg::RES_W-1:0];
          default: ;
        endcase
      end

      unique case (st)
        adsc_pkg::ST_IDLE: begin
          if (acc) begin
            unique case (item.data.func)
              adsc_pkg::FUNC_CLEAR: begin
                loaded   <= '0;
                total    <= '0;
                lo       <= '0;
                hi       <= m;
                tag      <= '0;
                fill     <= '0;
                decoded  <= '0;
                finished <= 1'b0;
              end
              adsc_pkg::FUNC_COUNT: begin
                if (mem_we) begin
                  total  <= cnt_sat;
                  loaded <= loaded + AW'(1);
                end
              end
              adsc_pkg::FUNC_BIT: begin
                n_cnt <= '0;
                ovr   <= 1'b0;
                bit_q <= item.data.code_bit;
                if (fill_path) begin
                  tag     <= {tag[PREC-2:0], item.data.code_bit} & m;
                  fill    <= fill_inc;
                  phase_b <= 1'b1;
                  if (fill_done) begin
                    lo <= '0;
                    hi <= m;
                  end
                end else begin
                  phase_b <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        adsc_pkg::ST_CHECK: begin
          priority if (finished) begin
          end else if (decoded >= seq_len) begin
            finished <= 1'b1;
          end else if (pending) begin
          end else if (n_cnt >= NNW'(RUN_CAP)) begin
            if (n_cnt != '0) ovr <= 1'b1;
          end else begin
            s <= '0;
          end
        end
        adsc_pkg::ST_TMUL: begin
          num  <= NW'(offs_v) * NW'(total) - NW'(1);
          den  <= DW'(width_v);
          rem  <= '0;
          dcnt <= '0;
        end
        adsc_pkg::ST_HMUL: begin
          num  <= NW'(width_v) * NW'(c_hi);
          den  <= DW'(total);
          rem  <= '0;
          dcnt <= '0;
        end
        adsc_pkg::ST_LMUL: begin
          num  <= NW'(width_v) * NW'(prev_c);
          den  <= DW'(total);
          rem  <= '0;
          dcnt <= '0;
        end
        adsc_pkg::ST_TDIV, adsc_pkg::ST_HDIV, adsc_pkg::ST_LDIV: begin
          num  <= num_nx;
          rem  <= rem_nx;
          dcnt <= dcnt + CW'(1);
          if (div_last) begin
            if (st == adsc_pkg::ST_TDIV) begin
              tn     <= num_nx[CUM_W-1:0];
              s      <= '0;
              prev_c <= '0;
            end else if (st == adsc_pkg::ST_HDIV) begin
              nh <= (lo + num_nx[PREC-1:0] - PREC'(1)) & m;
            end else begin
              hi <= nh;
              lo <= (lo + num_nx[PREC-1:0]) & m;
            end
          end
        end
        adsc_pkg::ST_SRD: ;
        adsc_pkg::ST_SCMP: begin
          if (scmp_adv) begin
            s      <= s + SW'(1);
            prev_c <= cur;
          end else begin
            c_hi <= cur;
          end
        end
        adsc_pkg::ST_EMIT: begin
          if (emit_go) begin
            decoded <= dec_nx;
            if (dec_nx >= seq_len) finished <= 1'b1;
            if (pend_v) out_q <= pend;
            pend   <= {sym_ext[SYM_W-1:0], 1'b0, (dec_nx >= seq_len), 1'b0};
            pend_v <= 1'b1;
            n_cnt  <= n_cnt + NNW'(1);
          end
        end
        adsc_pkg::ST_ENDRUN: begin
          if (resc_go) begin
            tag     <= tag_sh;
            lo      <= lo_sh;
            hi      <= hi_sh;
            phase_b <= 1'b1;
          end
        end
        adsc_pkg::ST_FINAL: begin
          if (pend_v && out_free) begin
            out_q  <= {pend.symbol, 1'b1, pend.done_res, ovr};
            pend_v <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  `ADSC_ASSERT_IMP(a_idle_no_pend, clk, rst, st == adsc_pkg::ST_IDLE, !pend_v, "held word left at idle")
  `ADSC_ASSERT_IMP(a_done_finished, clk, rst, pend_v && pend.done_res, finished, "done without finish")
  `ADSC_ASSERT_IMP(a_run_cap, clk, rst, 1'b1, n_cnt <= NNW'(RUN_CAP), "run exceeded cap")
  `ADSC_ASSERT_NXT(a_emit_holds, clk, rst, (st == adsc_pkg::ST_EMIT) && emit_go, pend_v, "emit lost word")

endmodule
